// File: hw/rtl/mck_pkg.sv
// mck_pkg: shared types, register codes and the character code table of the keyer
// used by the keyer modules other than the port checker, and by the channel interfaces
package mck_pkg;

    // configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_DOT        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DASH       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ELEM_GAP   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LETTER_GAP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WORD_GAP   = 3'd4;

    // register reset values
    localparam logic [3:0] DOT_RST        = 4'd1;
    localparam logic [3:0] DASH_RST       = 4'd3;
    localparam logic [3:0] ELEM_GAP_RST   = 4'd1;
    localparam logic [3:0] LETTER_GAP_RST = 4'd3;
    localparam logic [3:0] WORD_GAP_RST   = 4'd5;

    // default depth of the queue between front and back
    localparam int MCK_QUEUE_DEPTH = 2;

    // ascii codes that the classifier looks at
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_COMMA    = 8'd44;
    localparam logic [7:0] CH_PERIOD   = 8'd46;
    localparam logic [7:0] CH_QUESTION = 8'd63;

    // code table indexes for punctuation
    localparam logic [5:0] IDX_NONE     = 6'd0;
    localparam logic [5:0] IDX_COMMA    = 6'd37;
    localparam logic [5:0] IDX_PERIOD   = 6'd38;
    localparam logic [5:0] IDX_QUESTION = 6'd39;

    typedef struct packed {
        logic [3:0] dot_units;
        logic [3:0] dash_units;
        logic [3:0] element_gap_units;
        logic [3:0] letter_gap_units;
        logic [3:0] word_gap_units;
    } cfg_t;

    // element pattern: bit i set means element i is a dash, element 0 is sent first
    typedef struct packed {
        logic [2:0] len;
        logic [5:0] dash;
    } code_t;

    // classified item handed from front to back
    typedef struct packed {
        logic       is_space;
        logic       gap_before;
        code_t      code;
        logic       eom;
    } desc_t;

    // ascii byte to code table index, zero for bytes without a code
    function automatic logic [5:0] code_index(input logic [7:0] ch);
        logic [5:0] idx;
        if (ch > 8'd122)           idx = IDX_NONE;
        else if (ch > 8'd96)       idx = 6'(ch - 8'd96);
        else if (ch > 8'd90)       idx = IDX_NONE;
        else if (ch > 8'd64)       idx = 6'(ch - 8'd64);
        else if (ch == CH_QUESTION) idx = IDX_QUESTION;
        else if (ch > 8'd57)       idx = IDX_NONE;
        else if (ch > 8'd47)       idx = 6'(ch - 8'd21);
        else if (ch == CH_PERIOD)  idx = IDX_PERIOD;
        else if (ch == CH_COMMA)   idx = IDX_COMMA;
        else                       idx = IDX_NONE;
        return idx;
    endfunction

    // morse table: letters, digits, comma, period, question mark; the period entry holds -.-.-. not .-.-.-
    function automatic code_t code_lookup(input logic [5:0] idx);
        code_t c;
        unique case (idx)
            6'd1:  c = '{len: 3'd2, dash: 6'b000010};
            6'd2:  c = '{len: 3'd4, dash: 6'b000001};
            6'd3:  c = '{len: 3'd4, dash: 6'b000101};
            6'd4:  c = '{len: 3'd3, dash: 6'b000001};
            6'd5:  c = '{len: 3'd1, dash: 6'b000000};
            6'd6:  c = '{len: 3'd4, dash: 6'b000100};
            6'd7:  c = '{len: 3'd3, dash: 6'b000011};
            6'd8:  c = '{len: 3'd4, dash: 6'b000000};
            6'd9:  c = '{len: 3'd2, dash: 6'b000000};
            6'd10: c = '{len: 3'd4, dash: 6'b001110};
            6'd11: c = '{len: 3'd3, dash: 6'b000101};
            6'd12: c = '{len: 3'd4, dash: 6'b000010};
            6'd13: c = '{len: 3'd2, dash: 6'b000011};
            6'd14: c = '{len: 3'd2, dash: 6'b000001};
            6'd15: c = '{len: 3'd3, dash: 6'b000111};
            6'd16: c = '{len: 3'd4, dash: 6'b000110};
            6'd17: c = '{len: 3'd4, dash: 6'b001011};
            6'd18: c = '{len: 3'd3, dash: 6'b000010};
            6'd19: c = '{len: 3'd3, dash: 6'b000000};
            6'd20: c = '{len: 3'd1, dash: 6'b000001};
            6'd21: c = '{len: 3'd3, dash: 6'b000100};
            6'd22: c = '{len: 3'd4, dash: 6'b001000};
            6'd23: c = '{len: 3'd3, dash: 6'b000110};
            6'd24: c = '{len: 3'd4, dash: 6'b001001};
            6'd25: c = '{len: 3'd4, dash: 6'b001101};
            6'd26: c = '{len: 3'd4, dash: 6'b000011};
            6'd27: c = '{len: 3'd5, dash: 6'b011111};
            6'd28: c = '{len: 3'd5, dash: 6'b011110};
            6'd29: c = '{len: 3'd5, dash: 6'b011100};
            6'd30: c = '{len: 3'd5, dash: 6'b011000};
            6'd31: c = '{len: 3'd5, dash: 6'b010000};
            6'd32: c = '{len: 3'd5, dash: 6'b000000};
            6'd33: c = '{len: 3'd5, dash: 6'b000001};
            6'd34: c = '{len: 3'd5, dash: 6'b000011};
            6'd35: c = '{len: 3'd5, dash: 6'b000111};
            6'd36: c = '{len: 3'd5, dash: 6'b001111};
            6'd37: c = '{len: 3'd6, dash: 6'b110011};
            6'd38: c = '{len: 3'd6, dash: 6'b010101};
            6'd39: c = '{len: 3'd6, dash: 6'b001100};
            default: c = '{len: 3'd0, dash: 6'b000000};
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/mck_if.sv
// mck_if: valid/ready channel interfaces for text bytes in and led segments out
// depends on mck_pkg
interface mck_char_if
    import mck_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_message;

    modport source (output valid, character, end_of_message, input ready);
    modport sink   (input valid, character, end_of_message, output ready);
endinterface

interface mck_seg_if
    import mck_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic       led_on;
    logic [3:0] duration_units;
    logic       message_done;
    logic       last;

    modport source (output valid, led_on, duration_units, message_done, last, input ready);
    modport sink   (input valid, led_on, duration_units, message_done, last, output ready);
endinterface

// File: hw/rtl/mck_regs.sv
// mck_regs: apb register file holding the five segment durations
// depends on mck_pkg
module mck_regs
    import mck_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    logic [3:0]           wval;
    logic [3:0]           rval;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign wval   = pwdata[3:0];
    assign cfg    = cfg_reg;

    // write decode, unused indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DOT:        cfg_next.dot_units         = wval;
                REG_DASH:       cfg_next.dash_units        = wval;
                REG_ELEM_GAP:   cfg_next.element_gap_units = wval;
                REG_LETTER_GAP: cfg_next.letter_gap_units  = wval;
                REG_WORD_GAP:   cfg_next.word_gap_units    = wval;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_units         <= DOT_RST;
            cfg_reg.dash_units        <= DASH_RST;
            cfg_reg.element_gap_units <= ELEM_GAP_RST;
            cfg_reg.letter_gap_units  <= LETTER_GAP_RST;
            cfg_reg.word_gap_units    <= WORD_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read decode
    always_comb
    begin
        unique case (idx)
            REG_DOT:        rval = cfg_reg.dot_units;
            REG_DASH:       rval = cfg_reg.dash_units;
            REG_ELEM_GAP:   rval = cfg_reg.element_gap_units;
            REG_LETTER_GAP: rval = cfg_reg.letter_gap_units;
            REG_WORD_GAP:   rval = cfg_reg.word_gap_units;
            default:        rval = 4'd0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-4){1'b0}}, rval};

endmodule

// File: hw/rtl/mck_front.sv
// mck_front: accepts text bytes, classifies them and tracks the in-word state
// depends on mck_pkg and mck_if
module mck_front
    import mck_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mck_char_if.sink   char_in,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_data
);

    logic in_word_reg;
    logic in_word_next;
    logic is_space;

    assign char_in.ready = ~q_full;
    assign q_push        = char_in.valid & ~q_full;
    assign is_space      = (char_in.character == CH_SPACE);

    // classify the byte into a segment plan
    always_comb
    begin
        q_data.is_space   = is_space;
        q_data.gap_before = in_word_reg & ~is_space;
        q_data.code       = is_space ? code_t'('0)
                                     : code_lookup(code_index(char_in.character));
        q_data.eom        = char_in.end_of_message;
    end

    // in-word tracking: spaces and message ends leave the word
    always_comb
    begin
        in_word_next = in_word_reg;
        if (q_push)
            in_word_next = ~is_space & ~char_in.end_of_message;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_word_reg <= 1'b0;
        else
            in_word_reg <= in_word_next;
    end

endmodule

// File: hw/rtl/mck_queue.sv
// mck_queue: small register queue of classified items between front and back
// depends on mck_pkg
module mck_queue
    import mck_pkg::*;
#(
    parameter int DEPTH = MCK_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/mck_back.sv
// mck_back: walks the segment plan of the queue head, one led segment per cycle while the output is not stalled
// depends on mck_pkg and mck_if
module mck_back
    import mck_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  desc_t     head_data,
    output logic      pop,
    mck_seg_if.source seg_out
);

    logic [3:0] k_reg;
    logic [3:0] k_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       led_reg;
    logic [3:0] dur_reg;
    logic       done_reg;
    logic       last_reg;

    logic       pre;
    logic [3:0] body;
    logic [3:0] total;
    logic [3:0] j;
    logic [2:0] elem;
    logic       can_load;
    logic       emit;
    logic       seg_led;
    logic [3:0] seg_dur;
    logic       seg_done;
    logic       seg_last;

    // segment count of the head item
    always_comb
    begin
        pre = head_data.is_space | head_data.gap_before;
        if (head_data.is_space || head_data.code.len == 3'd0)
            body = 4'd0;
        else
            body = {head_data.code.len, 1'b0} - 4'd1;
        total = 4'(pre) + body + 4'(head_data.eom);
        j     = k_reg - 4'(pre);
        elem  = j[3:1];
    end

    // segment k of the plan
    always_comb
    begin
        seg_led  = 1'b0;
        seg_dur  = 4'd0;
        seg_done = 1'b0;
        if (k_reg < 4'(pre))
        begin
            seg_dur = head_data.is_space ? cfg.word_gap_units : cfg.letter_gap_units;
        end
        else if (j < body)
        begin
            if (j[0])
                seg_dur = cfg.element_gap_units;
            else
            begin
                seg_led = 1'b1;
                seg_dur = head_data.code.dash[elem] ? cfg.dash_units : cfg.dot_units;
            end
        end
        else
        begin
            seg_done = 1'b1;
        end
        seg_last = (k_reg == total - 4'd1);
    end

    // sequencing: items with an empty plan are dropped without a segment once the output can load
    assign can_load = ~out_valid_reg | seg_out.ready;
    assign emit     = can_load & head_valid & (total != 4'd0);
    assign pop      = can_load & head_valid & ((total == 4'd0) | seg_last);

    always_comb
    begin
        k_next = k_reg;
        if (pop)
            k_next = 4'd0;
        else if (emit)
            k_next = k_reg + 4'd1;
        out_valid_next = out_valid_reg;
        if (can_load)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            led_reg  <= seg_led;
            dur_reg  <= seg_dur;
            done_reg <= seg_done;
            last_reg <= seg_last;
        end
    end

    assign seg_out.valid          = out_valid_reg;
    assign seg_out.led_on         = led_reg;
    assign seg_out.duration_units = dur_reg;
    assign seg_out.message_done   = done_reg;
    assign seg_out.last           = last_reg;

endmodule

// File: hw/rtl/morse_code_keyer.sv
// morse_code_keyer: text bytes in, timed led segments out, durations set over apb
// an accepted byte passes a queue slot and the output register before its first segment is on the port
// throughput: one segment per cycle from the back sequencer while the output is not stalled; a byte
// has at most 13 segments, and a byte with no segments still holds a queue slot until it is dropped
// the front accepts while the queue (default depth 2) has room, so input and output stall separately
// reset: asynchronous active low; clears the queue, in-word state and output valid, resets the durations
module morse_code_keyer
    import mck_pkg::*;
#(
    parameter int QUEUE_DEPTH = MCK_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    mck_char_if.sink              char_in,
    mck_seg_if.source             seg_out
);

    cfg_t  cfg;
    logic  q_full;
    logic  q_push;
    desc_t q_data;
    logic  q_pop;
    logic  head_valid;
    desc_t head_data;

    // durations
    mck_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // byte classifier
    mck_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    // plan queue
    mck_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // segment sequencer
    mck_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (q_pop),
        .seg_out    (seg_out)
    );

endmodule

// File: hw/rtl/mck_checker.sv
// mck_port_checks: port-level checks on the keyer output channel, bound to the top level
// depends on morse_code_keyer
module mck_port_checks
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       led_on,
    input logic [3:0] duration_units,
    input logic       message_done,
    input logic       last
);

    // stalled segment holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_on)
            && $stable(duration_units) && $stable(message_done) && $stable(last))
        else $error("segment changed while stalled");

    // finish marker is dark, zero length and closes its item
    a_finish_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> !led_on && duration_units == 4'd0 && last)
        else $error("malformed finish marker");

    // nothing is offered right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("segment offered right after reset");

endmodule

bind morse_code_keyer mck_port_checks u_mck_port_checks
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (seg_out.valid),
    .out_ready      (seg_out.ready),
    .led_on         (seg_out.led_on),
    .duration_units (seg_out.duration_units),
    .message_done   (seg_out.message_done),
    .last           (seg_out.last)
);
